### rtl/lsos_pkg.sv
// Package for the lidar scan object segmenter: widths, register indexes,
// configuration, pipeline item and result types. No dependencies.
`default_nettype none

package lsos_pkg;

  localparam int unsigned MAX_RAYS  = 1024;
  localparam int unsigned RAY_IDX_W = $clog2(MAX_RAYS);
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned MARGIN_W  = 16;
  localparam int unsigned START_W   = 20;
  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned PROD_W    = RAY_IDX_W + STEP_W;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [MARGIN_W-1:0] ANGLE_MARGIN_RST = MARGIN_W'(655);
  localparam logic [MARGIN_W-1:0] DIST_MARGIN_RST  = MARGIN_W'(1000);

  typedef enum logic [1:0] {
    REG_START_ANGLE  = 2'd0,
    REG_ANGLE_STEP   = 2'd1,
    REG_ANGLE_MARGIN = 2'd2,
    REG_DIST_MARGIN  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [START_W-1:0] start_angle;
    logic [STEP_W-1:0]         angle_step;
    logic [MARGIN_W-1:0]       angle_margin;
    logic [MARGIN_W-1:0]       dist_margin;
  } cfg_t;

  // ray after the front stage: sample flags plus index times step
  typedef struct packed {
    logic [DIST_W-1:0] range_mm;
    logic              no_return;
    logic              end_of_scan;
    logic [PROD_W-1:0] prod;
  } ray_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] first_angle;
    logic [DIST_W-1:0]         first_distance;
    logic signed [ANGLE_W-1:0] final_angle;
    logic [DIST_W-1:0]         final_distance;
    logic [DIST_W-1:0]         nearest_distance;
    logic                      last_of_scan;
  } result_t;

endpackage

`default_nettype wire

### rtl/lsos_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on lsos_pkg.
`default_nettype none

module lsos_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lsos_pkg::APB_AW-1:0] paddr,
  input  wire logic [lsos_pkg::APB_DW-1:0] pwdata,
  output logic      [lsos_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output lsos_pkg::cfg_t                   cfg_o
);
  import lsos_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_START_ANGLE:  cfg_d.start_angle  = signed'(pwdata[START_W-1:0]);
        REG_ANGLE_STEP:   cfg_d.angle_step   = pwdata[STEP_W-1:0];
        REG_ANGLE_MARGIN: cfg_d.angle_margin = pwdata[MARGIN_W-1:0];
        REG_DIST_MARGIN:  cfg_d.dist_margin  = pwdata[MARGIN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_ANGLE:
        prdata = {{(APB_DW-START_W){cfg_q.start_angle[START_W-1]}}, cfg_q.start_angle};
      REG_ANGLE_STEP:   prdata = {{(APB_DW-STEP_W){1'b0}}, cfg_q.angle_step};
      REG_ANGLE_MARGIN: prdata = {{(APB_DW-MARGIN_W){1'b0}}, cfg_q.angle_margin};
      REG_DIST_MARGIN:  prdata = {{(APB_DW-MARGIN_W){1'b0}}, cfg_q.dist_margin};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle  <= '0;
      cfg_q.angle_step   <= '0;
      cfg_q.angle_margin <= ANGLE_MARGIN_RST;
      cfg_q.dist_margin  <= DIST_MARGIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lsos_front.sv
// Input stage: ray index counter, index times step product and the input
// register. Depends on lsos_pkg.
`default_nettype none

module lsos_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [lsos_pkg::DIST_W-1:0] range_mm_i,
  input  wire logic                        no_return_i,
  input  wire logic                        end_of_scan_i,
  input  wire logic [lsos_pkg::STEP_W-1:0] angle_step_i,
  input  wire logic                        room_i,
  output logic                             ray_valid_o,
  output lsos_pkg::ray_t                   ray_o,
  output logic                             advance_o
);
  import lsos_pkg::*;

  logic [RAY_IDX_W-1:0] idx_q, idx_d;
  logic                 valid_q, valid_d;
  ray_t                 ray_q, ray_d;
  logic                 accept;

  assign advance_o   = valid_q && room_i;
  assign in_stall_o  = valid_q && !room_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign ray_valid_o = valid_q;
  assign ray_o       = ray_q;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    ray_d   = ray_q;
    if (advance_o) valid_d = 1'b0;
    if (accept) begin
      valid_d           = 1'b1;
      ray_d.range_mm    = range_mm_i;
      ray_d.no_return   = no_return_i;
      ray_d.end_of_scan = end_of_scan_i;
      ray_d.prod        = PROD_W'(idx_q) * PROD_W'(angle_step_i);
      // hold the index at the last ray until the scan ends
      if (end_of_scan_i) begin
        idx_d = '0;
      end else if (idx_q != RAY_IDX_W'(MAX_RAYS - 1)) begin
        idx_d = idx_q + RAY_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q <= ray_d;
  end

endmodule

`default_nettype wire

### rtl/lsos_core.sv
// Segmentation core: angle, gap tests, open object state and the results
// of one ray. Depends on lsos_pkg.
`default_nettype none

module lsos_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lsos_pkg::cfg_t    cfg_i,
  input  wire lsos_pkg::ray_t    ray_i,
  input  wire logic              advance_i,
  output logic [1:0]             push_n_o,
  output lsos_pkg::result_t      res0_o,
  output lsos_pkg::result_t      res1_o
);
  import lsos_pkg::*;

  logic                      open_q, open_d;
  logic signed [ANGLE_W-1:0] first_ang_q, first_ang_d;
  logic [DIST_W-1:0]         first_dist_q, first_dist_d;
  logic [DIST_W-1:0]         min_q, min_d;
  logic signed [ANGLE_W-1:0] prev_ang_q, prev_ang_d;
  logic [DIST_W-1:0]         prev_dist_q, prev_dist_d;

  logic signed [ANGLE_W-1:0] angle;
  logic signed [ANGLE_W:0]   gap;
  logic [ANGLE_W:0]          gap_mag;
  logic [DIST_W-1:0]         dd;
  logic                      ret, join_obj, brk, fin;
  result_t                   closed, ended;

  assign ret   = !ray_i.no_return;
  assign angle = {{(ANGLE_W-START_W){cfg_i.start_angle[START_W-1]}}, cfg_i.start_angle}
               + {{(ANGLE_W-PROD_W){1'b0}}, ray_i.prod};
  assign gap     = {angle[ANGLE_W-1], angle} - {prev_ang_q[ANGLE_W-1], prev_ang_q};
  assign gap_mag = gap[ANGLE_W] ? unsigned'(-gap) : unsigned'(gap);
  assign dd      = (ray_i.range_mm > prev_dist_q) ? ray_i.range_mm - prev_dist_q
                                                  : prev_dist_q - ray_i.range_mm;
  assign join_obj = open_q
                 && (gap_mag <= {{(ANGLE_W+1-MARGIN_W){1'b0}}, cfg_i.angle_margin})
                 && (dd < cfg_i.dist_margin);
  assign brk = ret && open_q && !join_obj;

  always_comb begin
    open_d       = open_q;
    first_ang_d  = first_ang_q;
    first_dist_d = first_dist_q;
    min_d        = min_q;
    prev_ang_d   = prev_ang_q;
    prev_dist_d  = prev_dist_q;
    if (ret) begin
      open_d      = 1'b1;
      prev_ang_d  = angle;
      prev_dist_d = ray_i.range_mm;
      if (join_obj) begin
        if (ray_i.range_mm < min_q) min_d = ray_i.range_mm;
      end else begin
        // a breaking ray starts the next object
        first_ang_d  = angle;
        first_dist_d = ray_i.range_mm;
        min_d        = ray_i.range_mm;
      end
    end
    fin = ray_i.end_of_scan && open_d;
    if (ray_i.end_of_scan) open_d = 1'b0;
  end

  always_comb begin
    closed.first_angle      = first_ang_q;
    closed.first_distance   = first_dist_q;
    closed.final_angle      = prev_ang_q;
    closed.final_distance   = prev_dist_q;
    closed.nearest_distance = min_q;
    closed.last_of_scan     = 1'b0;
    ended.first_angle       = first_ang_d;
    ended.first_distance    = first_dist_d;
    ended.final_angle       = prev_ang_d;
    ended.final_distance    = prev_dist_d;
    ended.nearest_distance  = min_d;
    ended.last_of_scan      = 1'b1;
  end

  assign res0_o   = brk ? closed : ended;
  assign res1_o   = ended;
  assign push_n_o = advance_i ? (2'(brk) + 2'(fin)) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      first_ang_q  <= '0;
      first_dist_q <= '0;
      min_q        <= '0;
      prev_ang_q   <= '0;
      prev_dist_q  <= '0;
    end else if (advance_i) begin
      open_q       <= open_d;
      first_ang_q  <= first_ang_d;
      first_dist_q <= first_dist_d;
      min_q        <= min_d;
      prev_ang_q   <= prev_ang_d;
      prev_dist_q  <= prev_dist_d;
    end
  end

  a_two_results_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o == 2'd2) |-> (!res0_o.last_of_scan && res1_o.last_of_scan))
    else $error("two results from one ray out of order");

  a_scan_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ray_i.end_of_scan) |=> !open_q)
    else $error("object still open after scan end");

  a_break_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && brk) |-> $past(advance_i && !ray_i.no_return, 1) || open_q)
    else $error("break without an open object");

endmodule

`default_nettype wire

### rtl/lsos_outq.sv
// Four-entry result queue between the core and the output channel; takes
// up to two results a cycle. Depends on lsos_pkg.
`default_nettype none

module lsos_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire lsos_pkg::result_t res0_i,
  input  wire lsos_pkg::result_t res1_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lsos_pkg::result_t      head_o
);
  import lsos_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // room for the worst case of two results, ignoring this cycle's pop
  assign room_o      = (count_q <= CNT_W'(DEPTH - 2));
  assign head_o      = mem_q[head_q];

  always_comb begin
    head_d  = head_q + PTR_W'(pop);
    tail_d  = tail_q + PTR_W'(push_n_i);
    count_d = count_q + CNT_W'(push_n_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[tail_q] <= res0_i;
    if (push_n_i == 2'd2) mem_q[tail_q + PTR_W'(1)] <= res1_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> room_o)
    else $error("results pushed without room");

endmodule

`default_nettype wire

### rtl/lidar_scan_object_segmenter.sv
// Lidar scan object segmenter, top level. Ties the configuration port,
// input stage, segmentation core and result queue together. Uses lsos_pkg.
//
// Use: one range sample per item on the input channel (range_mm_i,
// no_return_i, end_of_scan_i), in scan order. Each closed object leaves as
// one item on the output channel with its first and last ray and its
// nearest distance; the object open at scan end carries last_of_scan_o.
// Both channels move an item at an edge where valid is high and stall low.
// A ray taken into the input register passes through the core into the
// result queue once the queue has room; its result is then offered on the
// output channel. Throughput: one item per cycle while rays give at most
// one result each and the output does not stall; the four-entry result
// queue accepts a ray only with room for two results, so a ray that
// closes one object and ends the scan costs a slot. A stall on the output
// fills the queue and then stalls the input.
// Reset empties the pipeline and queue, clears the open object and the ray
// index, and loads the register reset values. Write the registers over the
// APB-style port only while no item is in flight.
`default_nettype none

module lidar_scan_object_segmenter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lsos_pkg::APB_AW-1:0]   paddr,
  input  wire logic [lsos_pkg::APB_DW-1:0]   pwdata,
  output logic      [lsos_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lsos_pkg::DIST_W-1:0]   range_mm_i,
  input  wire logic                          no_return_i,
  input  wire logic                          end_of_scan_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [lsos_pkg::ANGLE_W-1:0] first_angle_o,
  output logic      [lsos_pkg::DIST_W-1:0]   first_distance_o,
  output logic signed [lsos_pkg::ANGLE_W-1:0] final_angle_o,
  output logic      [lsos_pkg::DIST_W-1:0]   final_distance_o,
  output logic      [lsos_pkg::DIST_W-1:0]   nearest_distance_o,
  output logic                               last_of_scan_o
);
  import lsos_pkg::*;

  cfg_t       cfg;
  ray_t       ray;
  logic       ray_valid;
  logic       advance;
  logic       room;
  logic [1:0] push_n;
  result_t    res0, res1, head;

  lsos_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsos_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .range_mm_i    (range_mm_i),
    .no_return_i   (no_return_i),
    .end_of_scan_i (end_of_scan_i),
    .angle_step_i  (cfg.angle_step),
    .room_i        (room),
    .ray_valid_o   (ray_valid),
    .ray_o         (ray),
    .advance_o     (advance)
  );

  lsos_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .ray_i     (ray),
    .advance_i (advance && ray_valid),
    .push_n_o  (push_n),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  lsos_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign first_angle_o      = head.first_angle;
  assign first_distance_o   = head.first_distance;
  assign final_angle_o      = head.final_angle;
  assign final_distance_o   = head.final_distance;
  assign nearest_distance_o = head.nearest_distance;
  assign last_of_scan_o     = head.last_of_scan;

endmodule

`default_nettype wire
